// ===== rtl/rfbs_pkg.sv =====
`timescale 1ns / 1ps

package rfbs_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned CoordW   = 16;
  localparam int unsigned ScreenW  = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Operation codes of a request beat.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COLUMN_OFFSET = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW_OFFSET    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COLUMN_SET    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROW_SET       = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MEMORY_WRITE  = 3'd6;

  // Register reset values.
  localparam logic [ScreenW-1:0] RST_SCREEN_WIDTH  = 10'd128;
  localparam logic [ScreenW-1:0] RST_SCREEN_HEIGHT = 10'd160;
  localparam logic [ByteW-1:0]   RST_COLUMN_OFFSET = 8'd0;
  localparam logic [ByteW-1:0]   RST_ROW_OFFSET    = 8'd0;
  localparam logic [ByteW-1:0]   RST_COLUMN_SET    = 8'd42;
  localparam logic [ByteW-1:0]   RST_ROW_SET       = 8'd43;
  localparam logic [ByteW-1:0]   RST_MEMORY_WRITE  = 8'd44;

  // Sequencer phase codes.
  localparam logic [PhaseW-1:0] PH_COL_CMD = 4'd0;
  localparam logic [PhaseW-1:0] PH_COL_S_H = 4'd1;
  localparam logic [PhaseW-1:0] PH_COL_S_L = 4'd2;
  localparam logic [PhaseW-1:0] PH_COL_E_H = 4'd3;
  localparam logic [PhaseW-1:0] PH_COL_E_L = 4'd4;
  localparam logic [PhaseW-1:0] PH_ROW_CMD = 4'd5;
  localparam logic [PhaseW-1:0] PH_ROW_S_H = 4'd6;
  localparam logic [PhaseW-1:0] PH_ROW_S_L = 4'd7;
  localparam logic [PhaseW-1:0] PH_ROW_E_H = 4'd8;
  localparam logic [PhaseW-1:0] PH_ROW_E_L = 4'd9;
  localparam logic [PhaseW-1:0] PH_MEM_CMD = 4'd10;
  localparam logic [PhaseW-1:0] PH_PIXELS  = 4'd11;

  typedef struct packed {
    logic [ScreenW-1:0] screen_width;
    logic [ScreenW-1:0] screen_height;
    logic [ByteW-1:0]   column_offset;
    logic [ByteW-1:0]   row_offset;
    logic [ByteW-1:0]   column_set_code;
    logic [ByteW-1:0]   row_set_code;
    logic [ByteW-1:0]   memory_write_code;
  } cfg_regs_t;

  typedef struct packed {
    logic               busy;
    logic [PhaseW-1:0]  phase;
    logic [CoordW-1:0]  col_start;
    logic [CoordW-1:0]  col_end;
    logic [CoordW-1:0]  row_start;
    logic [CoordW-1:0]  row_end;
    logic [CoordW-1:0]  held_color;
    logic [ScreenW-1:0] cols_left;
    logic [ScreenW-1:0] rows_left;
    logic               low_half_next;
  } fill_state_t;

  typedef struct packed {
    logic              emit;
    logic [ByteW-1:0]  out_byte;
    logic              is_data;
    logic              last_byte;
  } step_result_t;

endpackage

// ===== rtl/rect_fill_byte_sequencer_core.sv =====
`timescale 1ns / 1ps

// Rectangle-fill byte sequencer for a serial display controller.
// Request channel (req_valid / req_stall): a start beat (operation = 0) loads
// a rectangle and color; an advance beat (operation = 1) asks for the next
// byte of the transaction. The sequence is the column-set command and four
// address bytes, the row-set command and four address bytes, the
// memory-write command, then every pixel as high byte then low byte. The
// final pixel byte carries last_byte.
// Response channel (rsp_valid / rsp_stall): one beat per advance taken while
// a fill is running; starts and idle advances give no beat.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high; a
// write lands at the next clock edge. Write only while no fill is running.
//
// The byte for an advance is on the response port in the cycle after the
// request beat is taken. Throughput is one request beat per cycle while the
// response is not held; the whole step is a single pass of logic from the
// state registers into the response register.
// When the receiver stalls, the response register holds its beat and
// req_stall rises in the same cycle, so the next request waits.
// Synchronous reset clears the fill state, empties the response register
// and returns every configuration register to its default.
module rect_fill_byte_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  // Request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          operation,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_x,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_y,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_width,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_height,
  input  logic [rfbs_pkg::CoordW-1:0]   fill_color,
  // Response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [rfbs_pkg::ByteW-1:0]    out_byte,
  output logic                          is_data,
  output logic                          last_byte,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rfbs_pkg::CfgDataW-1:0] cfg_data
);
  import rfbs_pkg::*;

  cfg_regs_t    regs;
  fill_state_t  state;
  fill_state_t  state_next;
  step_result_t result;
  logic         req_take;
  logic         rsp_hold;

  assign cfg_ready = 1'b1;

  rfbs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  rfbs_step u_step (
    .cfg         (regs),
    .state       (state),
    .operation   (operation),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .fill_color  (fill_color),
    .state_next  (state_next),
    .result      (result)
  );

  // The response register is the only buffer: a request can be taken
  // whenever it is empty or its beat leaves in this cycle.
  assign rsp_hold  = rsp_valid && rsp_stall;
  assign req_stall = rsp_hold;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (req_take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_hold) begin
      rsp_valid <= req_take && result.emit;
    end
  end

  // Payload needs no reset; it only loads when a new beat is produced.
  always_ff @(posedge clk) begin
    if (req_take && result.emit) begin
      out_byte  <= result.out_byte;
      is_data   <= result.is_data;
      last_byte <= result.last_byte;
    end
  end

endmodule

// ===== rtl/rfbs_cfg.sv =====
`timescale 1ns / 1ps

module rfbs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [rfbs_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [rfbs_pkg::CfgDataW-1:0] wr_data,
  output rfbs_pkg::cfg_regs_t           regs
);
  import rfbs_pkg::*;

  // Writes to an index past the register list fall into the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.screen_width      <= RST_SCREEN_WIDTH;
      regs.screen_height     <= RST_SCREEN_HEIGHT;
      regs.column_offset     <= RST_COLUMN_OFFSET;
      regs.row_offset        <= RST_ROW_OFFSET;
      regs.column_set_code   <= RST_COLUMN_SET;
      regs.row_set_code      <= RST_ROW_SET;
      regs.memory_write_code <= RST_MEMORY_WRITE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCREEN_WIDTH:  regs.screen_width      <= wr_data[ScreenW-1:0];
        REG_SCREEN_HEIGHT: regs.screen_height     <= wr_data[ScreenW-1:0];
        REG_COLUMN_OFFSET: regs.column_offset     <= wr_data[ByteW-1:0];
        REG_ROW_OFFSET:    regs.row_offset        <= wr_data[ByteW-1:0];
        REG_COLUMN_SET:    regs.column_set_code   <= wr_data[ByteW-1:0];
        REG_ROW_SET:       regs.row_set_code      <= wr_data[ByteW-1:0];
        REG_MEMORY_WRITE:  regs.memory_write_code <= wr_data[ByteW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/rfbs_step.sv =====
`timescale 1ns / 1ps

module rfbs_step (
  input  rfbs_pkg::cfg_regs_t              cfg,
  input  rfbs_pkg::fill_state_t            state,
  input  logic                             operation,
  input  logic [rfbs_pkg::CoordW-1:0]      rect_x,
  input  logic [rfbs_pkg::CoordW-1:0]      rect_y,
  input  logic [rfbs_pkg::CoordW-1:0]      rect_width,
  input  logic [rfbs_pkg::CoordW-1:0]      rect_height,
  input  logic [rfbs_pkg::CoordW-1:0]      fill_color,
  output rfbs_pkg::fill_state_t            state_next,
  output rfbs_pkg::step_result_t           result
);
  import rfbs_pkg::*;

  logic [CoordW:0]    x_plus_w;
  logic [CoordW:0]    y_plus_h;
  logic               x_off;
  logic               y_off;
  logic [ScreenW-1:0] clip_w;
  logic [ScreenW-1:0] clip_h;
  logic               start_ok;
  logic [CoordW-1:0]  col_span;
  logic [ScreenW-1:0] row_reload;

  // Start path: reject, then clip to the screen. Once the origin is on
  // screen the clipped size always fits in ten bits.
  always_comb begin
    x_plus_w = {1'b0, rect_x} + {1'b0, rect_width};
    y_plus_h = {1'b0, rect_y} + {1'b0, rect_height};
    x_off    = rect_x >= {{(CoordW-ScreenW){1'b0}}, cfg.screen_width};
    y_off    = rect_y >= {{(CoordW-ScreenW){1'b0}}, cfg.screen_height};
    start_ok = (rect_width != '0) && (rect_height != '0) && !x_off && !y_off;
    clip_w   = (x_plus_w > {{(CoordW+1-ScreenW){1'b0}}, cfg.screen_width}) ?
               cfg.screen_width - rect_x[ScreenW-1:0] : rect_width[ScreenW-1:0];
    clip_h   = (y_plus_h > {{(CoordW+1-ScreenW){1'b0}}, cfg.screen_height}) ?
               cfg.screen_height - rect_y[ScreenW-1:0] : rect_height[ScreenW-1:0];
  end

  assign col_span   = state.col_end - state.col_start;
  assign row_reload = col_span[ScreenW-1:0] + ScreenW'(1);

  always_comb begin
    state_next       = state;
    result.emit      = 1'b0;
    result.out_byte  = '0;
    result.is_data   = 1'b1;
    result.last_byte = 1'b0;

    if (operation == OP_START) begin
      if (!state.busy && start_ok) begin
        state_next.col_start     = rect_x + {{(CoordW-ByteW){1'b0}}, cfg.column_offset};
        state_next.col_end       = rect_x + {{(CoordW-ScreenW){1'b0}}, clip_w}
                                   - CoordW'(1)
                                   + {{(CoordW-ByteW){1'b0}}, cfg.column_offset};
        state_next.row_start     = rect_y + {{(CoordW-ByteW){1'b0}}, cfg.row_offset};
        state_next.row_end       = rect_y + {{(CoordW-ScreenW){1'b0}}, clip_h}
                                   - CoordW'(1)
                                   + {{(CoordW-ByteW){1'b0}}, cfg.row_offset};
        state_next.held_color    = fill_color;
        state_next.cols_left     = clip_w;
        state_next.rows_left     = clip_h;
        state_next.low_half_next = 1'b0;
        state_next.phase         = PH_COL_CMD;
        state_next.busy          = 1'b1;
      end
    end else if (state.busy) begin
      result.emit      = 1'b1;
      state_next.phase = state.phase + PhaseW'(1);
      case (state.phase)
        PH_COL_CMD: begin
          result.out_byte = cfg.column_set_code;
          result.is_data  = 1'b0;
        end
        PH_COL_S_H: result.out_byte = state.col_start[CoordW-1:ByteW];
        PH_COL_S_L: result.out_byte = state.col_start[ByteW-1:0];
        PH_COL_E_H: result.out_byte = state.col_end[CoordW-1:ByteW];
        PH_COL_E_L: result.out_byte = state.col_end[ByteW-1:0];
        PH_ROW_CMD: begin
          result.out_byte = cfg.row_set_code;
          result.is_data  = 1'b0;
        end
        PH_ROW_S_H: result.out_byte = state.row_start[CoordW-1:ByteW];
        PH_ROW_S_L: result.out_byte = state.row_start[ByteW-1:0];
        PH_ROW_E_H: result.out_byte = state.row_end[CoordW-1:ByteW];
        PH_ROW_E_L: result.out_byte = state.row_end[ByteW-1:0];
        PH_MEM_CMD: begin
          result.out_byte = cfg.memory_write_code;
          result.is_data  = 1'b0;
          state_next.phase = PH_PIXELS;
        end
        default: begin
          // Pixel data: high byte, then low byte, then count the pixel off.
          state_next.phase = state.phase;
          if (!state.low_half_next) begin
            result.out_byte          = state.held_color[CoordW-1:ByteW];
            state_next.low_half_next = 1'b1;
          end else begin
            result.out_byte          = state.held_color[ByteW-1:0];
            state_next.low_half_next = 1'b0;
            if (state.cols_left > ScreenW'(1)) begin
              state_next.cols_left = state.cols_left - ScreenW'(1);
            end else if (state.rows_left > ScreenW'(1)) begin
              state_next.rows_left = state.rows_left - ScreenW'(1);
              state_next.cols_left = row_reload;
            end else begin
              result.last_byte     = 1'b1;
              state_next.busy      = 1'b0;
              state_next.phase     = PH_COL_CMD;
              state_next.cols_left = '0;
              state_next.rows_left = '0;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/rfbs_checker.sv =====
`timescale 1ns / 1ps

module rfbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic                          operation,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [rfbs_pkg::ByteW-1:0]    out_byte,
  input logic                          is_data,
  input logic                          last_byte
);
  import rfbs_pkg::*;

  // Reset leaves no response beat behind.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A held response must back-pressure the request side in the same cycle.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> req_stall)
    else $error("request accepted while response is held");

  // A start beat never produces a response beat.
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && operation == OP_START) |=> !rsp_valid)
    else $error("start beat produced a response");

  // A stalled response beat keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(out_byte) && $stable(is_data) && $stable(last_byte)))
    else $error("stalled response changed");

endmodule

bind rect_fill_byte_sequencer_core rfbs_checker u_rfbs_checker (.*);

// ===== tb/rfbs_fill_checker.sv =====
`timescale 1ns / 1ps

module rfbs_fill_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic                          operation,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_x,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_y,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_width,
  input  logic [rfbs_pkg::CoordW-1:0]   rect_height,
  input  logic [rfbs_pkg::CoordW-1:0]   fill_color,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic [rfbs_pkg::ByteW-1:0]    out_byte,
  input  logic                          is_data,
  input  logic                          last_byte,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rfbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rfbs_pkg::CfgDataW-1:0] cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            bytes_checked,
  output int                            fills_done,
  output int                            starts_taken
);
  import rfbs_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             data_flag;
    logic             last_flag;
  } link_byte_t;

  cfg_regs_t   regs;
  fill_state_t shadow;
  link_byte_t  expected_bytes[$];
  int          err_cnt, byte_cnt, fill_cnt, start_cnt;

  task automatic note_failure(input string what, input int want, input int got);
    err_cnt++;
    $error("%s: expected 0x%0h, got 0x%0h", what, want, got);
  endtask

  task automatic load_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      REG_SCREEN_WIDTH:  regs.screen_width      = val;
      REG_SCREEN_HEIGHT: regs.screen_height     = val;
      REG_COLUMN_OFFSET: regs.column_offset     = val[ByteW-1:0];
      REG_ROW_OFFSET:    regs.row_offset        = val[ByteW-1:0];
      REG_COLUMN_SET:    regs.column_set_code   = val[ByteW-1:0];
      REG_ROW_SET:       regs.row_set_code      = val[ByteW-1:0];
      REG_MEMORY_WRITE:  regs.memory_write_code = val[ByteW-1:0];
      default: ;
    endcase
  endtask

  // A start loads the clipped window; rejected or ignored starts leave no trace.
  task automatic accept_rectangle(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                  input logic [CoordW-1:0] w, input logic [CoordW-1:0] h,
                                  input logic [CoordW-1:0] color);
    int unsigned xi, yi, cw, ch, sw, sh;
    xi = 32'(x);
    yi = 32'(y);
    cw = 32'(w);
    ch = 32'(h);
    sw = 32'(regs.screen_width);
    sh = 32'(regs.screen_height);
    if (shadow.busy || cw == 0 || ch == 0) return;
    if (xi >= sw || yi >= sh) return;
    if (xi + cw > sw) cw = sw - xi;
    if (yi + ch > sh) ch = sh - yi;
    shadow.col_start     = CoordW'(xi + regs.column_offset);
    shadow.col_end       = CoordW'(xi + cw - 1 + regs.column_offset);
    shadow.row_start     = CoordW'(yi + regs.row_offset);
    shadow.row_end       = CoordW'(yi + ch - 1 + regs.row_offset);
    shadow.held_color    = color;
    shadow.cols_left     = ScreenW'(cw);
    shadow.rows_left     = ScreenW'(ch);
    shadow.low_half_next = 1'b0;
    shadow.phase         = PH_COL_CMD;
    shadow.busy          = 1'b1;
    start_cnt++;
  endtask

  // One advance while a fill runs yields exactly one byte on the link.
  task automatic predict_next_byte();
    link_byte_t b;
    if (!shadow.busy) return;
    b = '{value: '0, data_flag: 1'b1, last_flag: 1'b0};
    if (shadow.phase != PH_PIXELS) begin
      case (shadow.phase)
        PH_COL_CMD: begin
          b.value = regs.column_set_code;
          b.data_flag = 1'b0;
        end
        PH_COL_S_H: b.value = shadow.col_start[15:8];
        PH_COL_S_L: b.value = shadow.col_start[7:0];
        PH_COL_E_H: b.value = shadow.col_end[15:8];
        PH_COL_E_L: b.value = shadow.col_end[7:0];
        PH_ROW_CMD: begin
          b.value = regs.row_set_code;
          b.data_flag = 1'b0;
        end
        PH_ROW_S_H: b.value = shadow.row_start[15:8];
        PH_ROW_S_L: b.value = shadow.row_start[7:0];
        PH_ROW_E_H: b.value = shadow.row_end[15:8];
        PH_ROW_E_L: b.value = shadow.row_end[7:0];
        default: begin
          b.value = regs.memory_write_code;
          b.data_flag = 1'b0;
        end
      endcase
      shadow.phase = shadow.phase + PhaseW'(1);
    end else if (!shadow.low_half_next) begin
      b.value = shadow.held_color[15:8];
      shadow.low_half_next = 1'b1;
    end else begin
      b.value = shadow.held_color[7:0];
      shadow.low_half_next = 1'b0;
      if (shadow.cols_left > ScreenW'(1)) begin
        shadow.cols_left = shadow.cols_left - ScreenW'(1);
      end else if (shadow.rows_left > ScreenW'(1)) begin
        // Row done: reload the column count from the stored window.
        shadow.rows_left = shadow.rows_left - ScreenW'(1);
        shadow.cols_left = ScreenW'(shadow.col_end - shadow.col_start + CoordW'(1));
      end else begin
        b.last_flag      = 1'b1;
        shadow.busy      = 1'b0;
        shadow.phase     = PH_COL_CMD;
        shadow.cols_left = '0;
        shadow.rows_left = '0;
      end
    end
    expected_bytes.push_back(b);
  endtask

  always @(posedge clk) begin
    link_byte_t want;
    if (rst) begin
      regs = '{screen_width: RST_SCREEN_WIDTH, screen_height: RST_SCREEN_HEIGHT,
               column_offset: RST_COLUMN_OFFSET, row_offset: RST_ROW_OFFSET,
               column_set_code: RST_COLUMN_SET, row_set_code: RST_ROW_SET,
               memory_write_code: RST_MEMORY_WRITE};
      shadow = '0;
      expected_bytes.delete();
      err_cnt = 0;
      byte_cnt = 0;
      fill_cnt = 0;
      start_cnt = 0;
    end else begin
      // Responses come from a register and so always trail their request; pop first.
      if (rsp_valid && !rsp_stall) begin
        if (expected_bytes.size() == 0) begin
          note_failure("unexpected beat, out_byte", -1, int'(out_byte));
        end else begin
          want = expected_bytes.pop_front();
          byte_cnt++;
          if (want.last_flag) fill_cnt++;
          if (out_byte !== want.value) begin
            note_failure("out_byte", int'(want.value), int'(out_byte));
          end
          if (is_data !== want.data_flag) begin
            note_failure("is_data", int'(want.data_flag), int'(is_data));
          end
          if (last_byte !== want.last_flag) begin
            note_failure("last_byte", int'(want.last_flag), int'(last_byte));
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (operation == OP_START) begin
          accept_rectangle(rect_x, rect_y, rect_width, rect_height, fill_color);
        end else begin
          predict_next_byte();
        end
      end
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
    end
    mismatches    <= err_cnt;
    outstanding   <= expected_bytes.size();
    bytes_checked <= byte_cnt;
    fills_done    <= fill_cnt;
    starts_taken  <= start_cnt;
  end

endmodule

// ===== tb/rect_fill_byte_sequencer_core_test.sv =====
`timescale 1ns / 1ps

module rect_fill_byte_sequencer_core_test;
  import rfbs_pkg::*;

  // Useful request beats to send: accepted starts plus advances that make a byte.
  localparam int TARGET_ITEMS   = 450;
  // Useful beats per register setting before the next setting is loaded.
  localparam int ITEMS_PER_SET  = 60;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Extra cycles after the last byte; the core answers in the cycle after it takes a beat.
  localparam int DRAIN_CYCLES   = 4;
  // An index past the register list; the core must ignore writes to it.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic                operation = OP_ADVANCE;
  logic [CoordW-1:0]   rect_x = '0;
  logic [CoordW-1:0]   rect_y = '0;
  logic [CoordW-1:0]   rect_width = '0;
  logic [CoordW-1:0]   rect_height = '0;
  logic [CoordW-1:0]   fill_color = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [ByteW-1:0]    out_byte;
  logic                is_data;
  logic                last_byte;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int mismatches, outstanding, bytes_checked, fills_done, starts_taken;

  // Stimulus-side copy of the screen size, only used to size each fill so
  // that the right number of advance beats follows a start.
  int unsigned scr_w = 32'(RST_SCREEN_WIDTH);
  int unsigned scr_h = 32'(RST_SCREEN_HEIGHT);
  int          useful_items = 0;
  int          beat_count = 0;
  int          setting_count = 0;
  int          stall_left = 0;
  int          stuck_cycles = 0;
  // Set for the tail of the run: no sender gaps and no receiver stalls.
  bit          calm_tail = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  rect_fill_byte_sequencer_core u_top (.*);

  rfbs_fill_checker u_checker (.*);

  // Receiver: stalls in random bursts, with free-running stretches in
  // between, and never once the calm tail has begun.
  always @(posedge clk) begin
    if (rst || calm_tail) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      rsp_stall <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("rect_fill_byte_sequencer_core_test NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Present one request beat and hold it until the core takes it. A random
  // gap may come first, so idle cycles land on every phase of a fill.
  task automatic send_beat(input logic op, input logic [CoordW-1:0] x,
                           input logic [CoordW-1:0] y, input logic [CoordW-1:0] w,
                           input logic [CoordW-1:0] h, input logic [CoordW-1:0] color);
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    rect_x      <= x;
    rect_y      <= y;
    rect_width  <= w;
    rect_height <= h;
    fill_color  <= color;
    do @(posedge clk); while (req_stall);
    beat_count++;
  endtask

  // The rectangle fields of an advance beat are don't-care, so fill them
  // with noise to show the core ignores them.
  task automatic send_advance();
    send_beat(OP_ADVANCE, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
              CoordW'($urandom), CoordW'($urandom));
  endtask

  task automatic send_random_start();
    send_beat(OP_START, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
              CoordW'($urandom), CoordW'($urandom));
  endtask

  // Hold the request side idle until every byte owed has come out, then let
  // the response register settle before anything else touches the core.
  task automatic drain_bytes();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SCREEN_WIDTH) scr_w = 32'(val);
    if (idx == REG_SCREEN_HEIGHT) scr_h = 32'(val);
  endtask

  // Load a full register setting. Only done with the core idle and drained.
  task automatic load_setting(input int unsigned sw, input int unsigned sh,
                              input int unsigned col_off, input int unsigned row_off,
                              input int unsigned col_code, input int unsigned row_code,
                              input int unsigned mem_code);
    drain_bytes();
    write_reg(REG_SCREEN_WIDTH, CfgDataW'(sw));
    write_reg(REG_SCREEN_HEIGHT, CfgDataW'(sh));
    write_reg(REG_COLUMN_OFFSET, CfgDataW'(col_off));
    write_reg(REG_ROW_OFFSET, CfgDataW'(row_off));
    write_reg(REG_COLUMN_SET, CfgDataW'(col_code));
    write_reg(REG_ROW_SET, CfgDataW'(row_code));
    write_reg(REG_MEMORY_WRITE, CfgDataW'(mem_code));
    // A stray write past the register list must change nothing.
    if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, CfgDataW'($urandom));
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // Rotate through random settings and both extremes. Command codes go in
  // as 10-bit values so the core has to drop the upper bits.
  task automatic pick_setting(input int k);
    case (k % 4)
      0: load_setting($urandom_range(1, 1023), $urandom_range(1, 1023),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023));
      1: load_setting(1, 1, 0, 0, 0, 0, 0);
      2: load_setting(1023, 1023, 255, 255, 1023, 1023, 1023);
      default: load_setting($urandom_range(1, 8), $urandom_range(1, 8),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
    endcase
  endtask

  // A well-formed fill: one start, then exactly as many advances as the
  // clipped rectangle needs. Optionally a second start is slipped in while
  // the fill runs; the core must ignore it.
  task automatic run_fill(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                          input logic [CoordW-1:0] w, input logic [CoordW-1:0] h,
                          input logic [CoordW-1:0] color, input bit busy_start);
    int unsigned xi, yi, cw, ch, n, hit;
    xi = 32'(x);
    yi = 32'(y);
    cw = 32'(w);
    ch = 32'(h);
    if (xi + cw > scr_w) cw = scr_w - xi;
    if (yi + ch > scr_h) ch = scr_h - yi;
    // Eleven command and address bytes, then two bytes per pixel.
    n = 11 + 2 * cw * ch;
    hit = $urandom_range(0, n - 1);
    send_beat(OP_START, x, y, w, h, color);
    useful_items++;
    for (int unsigned i = 0; i < n; i++) begin
      if (busy_start && i == hit) send_random_start();
      send_advance();
      useful_items++;
    end
  endtask

  // Random fill shapes: mostly tiny windows, some clipped at the right or
  // bottom edge with huge sizes, and now and then a wider block.
  task automatic random_fill();
    logic [CoordW-1:0] x, y, w, h;
    int unsigned       kind;
    kind = $urandom_range(0, 15);
    x = CoordW'($urandom_range(0, scr_w - 1));
    y = CoordW'($urandom_range(0, scr_h - 1));
    w = CoordW'($urandom_range(1, 3));
    h = CoordW'($urandom_range(1, 3));
    if (kind < 4) begin
      x = CoordW'(scr_w - $urandom_range(1, (scr_w < 3) ? scr_w : 3));
      w = CoordW'($urandom_range(1, 65535));
    end else if (kind < 8) begin
      y = CoordW'(scr_h - $urandom_range(1, (scr_h < 3) ? scr_h : 3));
      h = CoordW'($urandom_range(1, 65535));
    end else if (kind == 15) begin
      w = CoordW'($urandom_range(8, 24));
      h = CoordW'($urandom_range(2, 5));
    end
    run_fill(x, y, w, h, CoordW'($urandom), $urandom_range(0, 3) == 0);
  endtask

  // Beats the core must swallow without a byte: advances while idle, starts
  // with a zero size, and starts whose origin lies off the screen.
  task automatic random_noise();
    case ($urandom_range(0, 3))
      0: send_advance();
      1: send_beat(OP_START, CoordW'($urandom), CoordW'($urandom), 16'd0,
                   CoordW'($urandom), CoordW'($urandom));
      2: send_beat(OP_START, CoordW'($urandom), CoordW'($urandom),
                   CoordW'($urandom_range(1, 65535)), 16'd0, CoordW'($urandom));
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          send_beat(OP_START, CoordW'($urandom_range(scr_w, 65535)), CoordW'($urandom),
                    CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
        end else begin
          send_beat(OP_START, CoordW'($urandom), CoordW'($urandom_range(scr_h, 65535)),
                    CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
        end
      end
    endcase
  endtask

  initial begin
    int k;
    int goal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset setting (128 x 160, codes 42/43/44).
    send_advance();                                        // idle advance
    send_beat(OP_START, 16'd5, 16'd5, 16'd0, 16'd4, 16'h1234);       // zero width
    send_beat(OP_START, 16'd5, 16'd5, 16'd4, 16'd0, 16'h1234);       // zero height
    send_beat(OP_START, 16'd128, 16'd0, 16'd1, 16'd1, 16'h1234);     // x off screen
    send_beat(OP_START, 16'd0, 16'd160, 16'd1, 16'd1, 16'h1234);     // y off screen
    // Bottom-right pixel with maximal sizes, clipped down to one pixel; a
    // one-pixel start at the origin arrives mid-fill and must be ignored.
    send_beat(OP_START, 16'd127, 16'd159, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 13; i++) begin
      if (i == 6) send_beat(OP_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'h0000);
      send_advance();
    end
    useful_items += 14;

    // A zero-sized screen rejects every start.
    load_setting(0, 0, 0, 0, 1023, 1023, 1023);
    send_beat(OP_START, 16'd0, 16'd0, 16'd1, 16'd1, 16'hA5A5);
    send_advance();

    // Random part: a fresh setting every ITEMS_PER_SET useful beats, with the
    // sender waiting for every byte to drain before each new setting.
    k = 0;
    while (useful_items < TARGET_ITEMS) begin
      pick_setting(k);
      k++;
      goal = useful_items + ITEMS_PER_SET;
      if (goal >= TARGET_ITEMS) calm_tail <= 1'b1;
      while (useful_items < goal) begin
        if ($urandom_range(0, 4) == 0) random_noise();
        else random_fill();
        if ($urandom_range(0, 15) == 0) drain_bytes();
      end
    end

    drain_bytes();
    $display("Sent %0d request beats over %0d register settings (screen 0x0 up to 1023x1023).",
             beat_count, setting_count);
    $display("Checked %0d bytes from %0d accepted starts and %0d completed fills.",
             bytes_checked, starts_taken, fills_done);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rect_fill_byte_sequencer_core_test OK");
    end else begin
      $display("rect_fill_byte_sequencer_core_test NOT OK");
    end
    $finish;
  end

endmodule
